[hdl/lcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lock order checker package
// Sizes, result codes and the stack cell control word shared by the core.
// ----------------------------------------------------------------------------
package lcc_pkg;

  localparam int MAX_LOCKS   = 64;
  localparam int MAX_THREADS = 16;
  localparam int HELD_DEPTH  = 8;

  localparam int ADDR_W  = 48;
  localparam int TID_W   = 16;
  localparam int RANK_W  = $clog2(MAX_LOCKS);
  localparam int LCNT_W  = $clog2(MAX_LOCKS + 1);
  localparam int SLOT_W  = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int TCNT_W  = $clog2(MAX_THREADS + 1);
  localparam int DEPTH_W = $clog2(HELD_DEPTH + 1);
  localparam int DIDX_W  = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int ROW_W   = HELD_DEPTH * RANK_W;

  // result field widths
  localparam int STATUS_W   = 3;
  localparam int OUT_RANK_W = 6;
  localparam int OUT_CNT_W  = 4;

  localparam logic REQ_ACQUIRE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_ORDER       = 3'd1,
    ST_NOT_HELD    = 3'd2,
    ST_LOCK_FULL   = 3'd3,
    ST_THREAD_FULL = 3'd4,
    ST_HELD_FULL   = 3'd5
  } status_t;

  // push writes the lane at pos; pull shifts lanes from pos upwards down by one
  typedef struct packed {
    logic              push;
    logic              pull;
    logic [DIDX_W-1:0] pos;
  } stk_ctrl_t;

endpackage

[hdl/lcc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/lcc_lock_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lock table cell
// Holds one lock address and flags a match against the broadcast key.
// ----------------------------------------------------------------------------
module lcc_lock_cell (
  input  logic                       clk,
  input  logic                       live,
  input  logic                       wr_en,
  input  logic [lcc_pkg::ADDR_W-1:0] key,
  output logic                       hit_r
);
  import lcc_pkg::*;

  logic [ADDR_W-1:0] addr_r;

  // load address, register compare
  always_ff @(posedge clk) begin
    if (wr_en) begin
      addr_r <= key;
    end
    hit_r <= live && (addr_r == key);
  end

endmodule

[hdl/lcc_thr_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thread table cell
// Holds one thread id and flags a match against the broadcast key.
// ----------------------------------------------------------------------------
module lcc_thr_cell (
  input  logic                      clk,
  input  logic                      live,
  input  logic                      wr_en,
  input  logic [lcc_pkg::TID_W-1:0] key,
  output logic                      hit_r
);
  import lcc_pkg::*;

  logic [TID_W-1:0] tid_r;

  // load id, register compare
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tid_r <= key;
    end
    hit_r <= live && (tid_r == key);
  end

endmodule

[hdl/lcc_stk_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Held stack lane
// Computes one lane of a thread's held list after a push or a removal.
// ----------------------------------------------------------------------------
module lcc_stk_cell (
  input  lcc_pkg::stk_ctrl_t          ctrl,
  input  logic [lcc_pkg::DIDX_W-1:0]  idx,
  input  logic [lcc_pkg::RANK_W-1:0]  own,
  input  logic [lcc_pkg::RANK_W-1:0]  upper,
  input  logic [lcc_pkg::RANK_W-1:0]  new_rank,
  output logic [lcc_pkg::RANK_W-1:0]  nxt
);
  import lcc_pkg::*;

  // take the new rank, the neighbour above, or hold
  always_comb begin
    nxt = own;
    if (ctrl.push && (idx == ctrl.pos)) begin
      nxt = new_rank;
    end else if (ctrl.pull && (idx >= ctrl.pos)) begin
      nxt = upper;
    end
  end

endmodule

[hdl/lock_order_checker_core.sv]
`timescale 1ns / 1ps
// Sequence: an accepted request is registered, then the compare, encode and
// evaluate steps run in turn through the lock and thread cell rows and the held
// list RAM; the result is registered once out is free. A new request is taken
// only back in idle, so the block waits longer while a result waits on out_stall.
// Reset: lock and thread counts and all held depths clear at once, nesting is
// allowed; table and held list contents are not cleared.
// ----------------------------------------------------------------------------
// Lock order checker core
// Ranks locks in discovery order and checks each thread's acquire order.
// ----------------------------------------------------------------------------
module lock_order_checker_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_req_type,
  input  logic [lcc_pkg::TID_W-1:0]      in_thread_id,
  input  logic [lcc_pkg::ADDR_W-1:0]     in_lock_addr,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lcc_pkg::STATUS_W-1:0]   out_status,
  output logic [lcc_pkg::OUT_RANK_W-1:0] out_lock_rank,
  output logic [lcc_pkg::OUT_RANK_W-1:0] out_top_rank,
  output logic [lcc_pkg::OUT_CNT_W-1:0]  out_held_count
);
  import lcc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_ENC, S_EVAL} state_t;

  state_t state_r, state_nxt;

  logic                  nest_r;
  logic                  req_r;
  logic [TID_W-1:0]      tid_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [LCNT_W-1:0]     lock_total_r;
  logic [TCNT_W-1:0]     thread_total_r;
  logic [DEPTH_W-1:0]    depth_tab_r [MAX_THREADS];
  logic [RANK_W-1:0]     rank_r;
  logic [SLOT_W-1:0]     slot_r;
  logic                  lknown_r;
  logic                  tknown_r;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [OUT_RANK_W-1:0] out_lock_rank_r;
  logic [OUT_RANK_W-1:0] out_top_rank_r;
  logic [OUT_CNT_W-1:0]  out_held_count_r;

  logic [MAX_LOCKS-1:0]   lhit;
  logic [MAX_THREADS-1:0] thit;
  logic [RANK_W-1:0]      rank_enc;
  logic [SLOT_W-1:0]      slot_enc;
  logic [ROW_W-1:0]       row_rd;
  logic [ROW_W-1:0]       row_new;
  logic [RANK_W-1:0]      lane [HELD_DEPTH];

  logic                   commit;
  logic [DEPTH_W-1:0]     depth_cur;
  logic [DEPTH_W-1:0]     depth_m1;
  logic [DEPTH_W-1:0]     depth_new;
  logic [RANK_W-1:0]      top;
  logic [RANK_W-1:0]      rank_eff;
  logic [SLOT_W-1:0]      slot_eff;
  logic [HELD_DEPTH-1:0]  rel_hit;
  logic [DIDX_W-1:0]      rel_pos;
  status_t                status;
  logic                   acq_ok;
  logic                   rel_ok;
  logic                   lock_wr;
  logic                   thr_wr;
  stk_ctrl_t              sctl;

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_lock_rank  = out_lock_rank_r;
  assign out_top_rank   = out_top_rank_r;
  assign out_held_count = out_held_count_r;

  // lock table cells
  for (genvar i = 0; i < MAX_LOCKS; i++) begin : g_lock
    lcc_lock_cell u_cell (
      .clk   (clk),
      .live  (LCNT_W'(i) < lock_total_r),
      .wr_en (lock_wr && (LCNT_W'(i) == lock_total_r)),
      .key   (addr_r),
      .hit_r (lhit[i])
    );
  end

  // thread table cells
  for (genvar i = 0; i < MAX_THREADS; i++) begin : g_thr
    lcc_thr_cell u_cell (
      .clk   (clk),
      .live  (TCNT_W'(i) < thread_total_r),
      .wr_en (thr_wr && (TCNT_W'(i) == thread_total_r)),
      .key   (tid_r),
      .hit_r (thit[i])
    );
  end

  // encode the one-hot match rows
  always_comb begin
    rank_enc = '0;
    slot_enc = '0;
    for (int i = 0; i < MAX_LOCKS; i++) begin
      rank_enc = rank_enc | (lhit[i] ? RANK_W'(i) : RANK_W'(0));
    end
    for (int i = 0; i < MAX_THREADS; i++) begin
      slot_enc = slot_enc | (thit[i] ? SLOT_W'(i) : SLOT_W'(0));
    end
  end

  // held list rows, one per thread slot
  lcc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_THREADS), .AW(SLOT_W)) u_held (
    .clk     (clk),
    .wr_en   (commit && (status == ST_OK)),
    .wr_addr (slot_eff),
    .wr_data (row_new),
    .rd_en   (state_r == S_ENC),
    .rd_addr (slot_enc),
    .rd_data (row_rd)
  );

  // evaluate the event against the thread's held list
  always_comb begin
    for (int k = 0; k < HELD_DEPTH; k++) begin
      lane[k] = row_rd[k*RANK_W +: RANK_W];
    end
    depth_cur = tknown_r ? depth_tab_r[slot_r] : '0;
    depth_m1  = depth_cur - DEPTH_W'(1);
    top       = (depth_cur != '0) ? lane[depth_m1[DIDX_W-1:0]] : '0;
    rank_eff  = lknown_r ? rank_r : lock_total_r[RANK_W-1:0];
    slot_eff  = tknown_r ? slot_r : thread_total_r[SLOT_W-1:0];

    // most recent matching entry below the depth
    rel_pos = '0;
    for (int k = 0; k < HELD_DEPTH; k++) begin
      rel_hit[k] = (DEPTH_W'(k) < depth_cur) && (lane[k] == rank_r);
      if (rel_hit[k]) begin
        rel_pos = DIDX_W'(k);
      end
    end

    if (req_r == REQ_ACQUIRE) begin
      if (!lknown_r && (lock_total_r >= LCNT_W'(MAX_LOCKS))) begin
        status = ST_LOCK_FULL;
      end else if (!tknown_r && (thread_total_r >= TCNT_W'(MAX_THREADS))) begin
        status = ST_THREAD_FULL;
      end else if ((depth_cur != '0) &&
                   ((rank_eff < top) || (!nest_r && (rank_eff == top)))) begin
        status = ST_ORDER;
      end else if (depth_cur >= DEPTH_W'(HELD_DEPTH)) begin
        status = ST_HELD_FULL;
      end else begin
        status = ST_OK;
      end
    end else begin
      status = (lknown_r && tknown_r && (|rel_hit)) ? ST_OK : ST_NOT_HELD;
    end

    acq_ok = (status == ST_OK) && (req_r == REQ_ACQUIRE);
    rel_ok = (status == ST_OK) && (req_r == REQ_RELEASE);
    if (acq_ok) begin
      depth_new = depth_cur + DEPTH_W'(1);
    end else if (rel_ok) begin
      depth_new = depth_m1;
    end else begin
      depth_new = depth_cur;
    end

    sctl.push = acq_ok;
    sctl.pull = rel_ok;
    sctl.pos  = acq_ok ? depth_cur[DIDX_W-1:0] : rel_pos;
  end

  // held list lanes, each fed by its neighbour above (the top lane by itself)
  for (genvar k = 0; k < HELD_DEPTH; k++) begin : g_stk
    lcc_stk_cell u_cell (
      .ctrl     (sctl),
      .idx      (DIDX_W'(k)),
      .own      (lane[k]),
      .upper    (lane[(k + 1 < HELD_DEPTH) ? k + 1 : k]),
      .new_rank (rank_eff),
      .nxt      (row_new[k*RANK_W +: RANK_W])
    );
  end

  assign commit  = (state_r == S_EVAL) && (!out_valid_r || !out_stall);
  assign lock_wr = commit && acq_ok && !lknown_r;
  assign thr_wr  = commit && acq_ok && !tknown_r;

  // sequence the steps of one transaction
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_ENC;
      S_ENC:   state_nxt = S_EVAL;
      S_EVAL:  if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state, tables and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      nest_r         <= 1'b1;
      lock_total_r   <= '0;
      thread_total_r <= '0;
      out_valid_r    <= 1'b0;
      for (int t = 0; t < MAX_THREADS; t++) begin
        depth_tab_r[t] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        nest_r <= cfg_wr_data;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
        if (lock_wr) begin
          lock_total_r <= lock_total_r + LCNT_W'(1);
        end
        if (thr_wr) begin
          thread_total_r <= thread_total_r + TCNT_W'(1);
        end
        if (status == ST_OK) begin
          depth_tab_r[slot_eff] <= depth_new;
        end
      end
    end

    // payload, no reset
    if (state_r == S_IDLE && in_valid) begin
      req_r  <= in_req_type;
      tid_r  <= in_thread_id;
      addr_r <= in_lock_addr;
    end
    if (state_r == S_ENC) begin
      rank_r   <= rank_enc;
      slot_r   <= slot_enc;
      lknown_r <= |lhit;
      tknown_r <= |thit;
    end
    if (commit) begin
      out_status_r     <= status;
      out_lock_rank_r  <= (lknown_r || acq_ok) ? OUT_RANK_W'(rank_eff) : '0;
      out_top_rank_r   <= OUT_RANK_W'(top);
      out_held_count_r <= OUT_CNT_W'(depth_new);
    end
  end

  // a lock address or thread id sits in at most one cell
  a_lock_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENC) |-> $onehot0(lhit))
    else $error("lock address matched in several cells");

  a_thr_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENC) |-> $onehot0(thit))
    else $error("thread id matched in several cells");

  a_lock_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lock_total_r <= LCNT_W'(MAX_LOCKS))
    else $error("lock count past table size");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> (depth_cur <= DEPTH_W'(HELD_DEPTH)))
    else $error("held depth past list size");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("result not posted after evaluation");

endmodule

[tb/lock_order_checker_core_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lock order checker scoreboard
// Watches both channels, predicts each result from its own copy of the lock
// and thread tables and compares every result field with the oldest expected.
// ----------------------------------------------------------------------------
module lock_order_checker_core_chk
  import lcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [TID_W-1:0]      in_thread_id,
  input  logic [ADDR_W-1:0]     in_lock_addr,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [STATUS_W-1:0]   out_status,
  input  logic [OUT_RANK_W-1:0] out_lock_rank,
  input  logic [OUT_RANK_W-1:0] out_top_rank,
  input  logic [OUT_CNT_W-1:0]  out_held_count,
  output int                    fail_count,
  output int                    pending_count
);

  typedef struct packed {
    status_t               status;
    logic [OUT_RANK_W-1:0] lock_rank;
    logic [OUT_RANK_W-1:0] top_rank;
    logic [OUT_CNT_W-1:0]  held_count;
  } verdict_t;

  verdict_t    verdict_q[$];
  logic [ADDR_W-1:0] rank_addr[MAX_LOCKS];
  int          locks_known;
  logic [TID_W-1:0] slot_tid[MAX_THREADS];
  int          threads_known;
  int          stack_rank[MAX_THREADS][HELD_DEPTH];
  int          stack_depth[MAX_THREADS];
  logic        nesting_ok;

  // Work out the verdict of one transaction and update the shadow tables
  function automatic verdict_t judge_event(logic rel, logic [TID_W-1:0] tid,
                                           logic [ADDR_W-1:0] addr);
    verdict_t v;
    int rank, slot, depth, top, j;
    bit lknown, tknown, in_table;
    status_t st;
    rank = 0; slot = 0; depth = 0; top = 0;
    lknown = 0; tknown = 0; st = ST_OK;
    for (int i = 0; i < locks_known; i++)
      if (!lknown && rank_addr[i] == addr) begin
        lknown = 1;
        rank = i;
      end
    for (int i = 0; i < threads_known; i++)
      if (!tknown && slot_tid[i] == tid) begin
        tknown = 1;
        slot = i;
      end
    in_table = lknown;
    if (tknown) begin
      depth = stack_depth[slot];
      if (depth > 0) top = stack_rank[slot][depth-1];
    end
    if (rel == REQ_ACQUIRE) begin
      if (!lknown && locks_known >= MAX_LOCKS) begin
        st = ST_LOCK_FULL;
      end else begin
        if (!lknown) rank = locks_known;
        if (!tknown && threads_known >= MAX_THREADS) st = ST_THREAD_FULL;
        else if (depth > 0 && (rank < top || (!nesting_ok && rank == top))) st = ST_ORDER;
        else if (depth >= HELD_DEPTH) st = ST_HELD_FULL;
      end
      if (st == ST_OK) begin
        if (!lknown) begin
          rank_addr[rank] = addr;
          locks_known++;
          in_table = 1;
        end
        if (!tknown) begin
          slot = threads_known;
          slot_tid[slot] = tid;
          threads_known++;
          depth = 0;
        end
        stack_rank[slot][depth] = rank;
        depth++;
        stack_depth[slot] = depth;
      end
    end else begin
      st = ST_NOT_HELD;
      if (lknown && tknown) begin
        j = depth;
        while (j > 0 && st != ST_OK) begin
          j--;
          if (stack_rank[slot][j] == rank) begin
            for (int k = j; k + 1 < depth; k++) stack_rank[slot][k] = stack_rank[slot][k+1];
            depth--;
            stack_depth[slot] = depth;
            st = ST_OK;
          end
        end
      end
    end
    v.status     = st;
    v.lock_rank  = in_table ? rank[OUT_RANK_W-1:0] : '0;
    v.top_rank   = top[OUT_RANK_W-1:0];
    v.held_count = depth[OUT_CNT_W-1:0];
    return v;
  endfunction

  assign pending_count = verdict_q.size();

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      verdict_q.delete();
      locks_known   = 0;
      threads_known = 0;
      nesting_ok    = 1'b1;
      for (int i = 0; i < MAX_THREADS; i++) stack_depth[i] = 0;
    end else begin
      // Check the result transaction against the oldest expectation
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result transaction, status %0d", out_status);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          if (out_lock_rank !== want.lock_rank) begin
            $error("lock_rank: expected %0d, got %0d", want.lock_rank, out_lock_rank);
            fail_count++;
          end
          if (out_top_rank !== want.top_rank) begin
            $error("top_rank: expected %0d, got %0d", want.top_rank, out_top_rank);
            fail_count++;
          end
          if (out_held_count !== want.held_count) begin
            $error("held_count: expected %0d, got %0d", want.held_count, out_held_count);
            fail_count++;
          end
        end
      end
      if (cfg_wr_en) nesting_ok = cfg_wr_data;
      // Predict the input transaction
      if (in_valid && !in_stall)
        verdict_q.push_back(judge_event(in_req_type, in_thread_id, in_lock_addr));
    end
  end

  initial fail_count = 0;

endmodule

[tb/lock_order_checker_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lock order checker testbench
// Drives directed and random acquire/release traffic with random gaps and
// stalls through several nesting settings; the scoreboard checks each result.
// ----------------------------------------------------------------------------
module lock_order_checker_core_tb;
  import lcc_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic                  cfg_wr_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_req_type;
  logic [TID_W-1:0]      in_thread_id;
  logic [ADDR_W-1:0]     in_lock_addr;
  logic                  out_valid;
  logic                  out_stall;
  logic [STATUS_W-1:0]   out_status;
  logic [OUT_RANK_W-1:0] out_lock_rank;
  logic [OUT_RANK_W-1:0] out_top_rank;
  logic [OUT_CNT_W-1:0]  out_held_count;
  int                    fail_count;
  int                    pending_count;
  logic                  stall_enable;

  // Pools of addresses and thread ids in use in the current phase
  logic [ADDR_W-1:0] addr_pool[MAX_LOCKS + 8];
  logic [TID_W-1:0]  tid_pool[MAX_THREADS + 4];
  int                addr_span;
  int                tid_span;

  lock_order_checker_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_thread_id(in_thread_id), .in_lock_addr(in_lock_addr),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_lock_rank(out_lock_rank), .out_top_rank(out_top_rank),
    .out_held_count(out_held_count)
  );

  lock_order_checker_core_chk u_chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_thread_id(in_thread_id), .in_lock_addr(in_lock_addr),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_lock_rank(out_lock_rank), .out_top_rank(out_top_rank),
    .out_held_count(out_held_count),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Randomly stall the result transaction that follows each accepted one
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        hold = stall_enable ? int'($urandom_range(0, 4)) : 0;
        if (hold != 0) begin
          out_stall <= 1'b1;
          do @(posedge clk); while (!out_valid);
          repeat (hold - 1) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Present one transaction and hold it until accepted
  task automatic send_event(logic rel, logic [TID_W-1:0] tid, logic [ADDR_W-1:0] addr,
                            bit gaps);
    int wait_cycles;
    wait_cycles = gaps ? int'($urandom_range(0, 4)) : 0;
    if (wait_cycles != 0) begin
      in_valid <= 1'b0;
      repeat (wait_cycles) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= rel;
    in_thread_id <= tid;
    in_lock_addr <= addr;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_nesting(logic val);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Fresh random pools for a phase
  task automatic fill_pools(int n_addr, int n_tid);
    for (int i = 0; i < MAX_LOCKS + 8; i++)
      addr_pool[i] = ADDR_W'({$urandom(), $urandom()});
    for (int i = 0; i < MAX_THREADS + 4; i++)
      tid_pool[i] = TID_W'($urandom());
    addr_span = n_addr;
    tid_span  = n_tid;
  endtask

  // Random acquire/release traffic on the pools mixed with noise
  task automatic random_traffic(int count);
    logic [ADDR_W-1:0] a;
    logic [TID_W-1:0]  t;
    int                pick;
    for (int n = 0; n < count; n++) begin
      stall_enable = (n % 200) < 150;
      pick = int'($urandom_range(0, 9));
      t = tid_pool[$urandom_range(0, tid_span - 1)];
      if (pick < 7) begin
        // a random pool address on a pool thread, acquire or release
        a = addr_pool[$urandom_range(0, addr_span - 1)];
        send_event(pick >= 4 ? REQ_RELEASE : REQ_ACQUIRE, t, a, (n % 100) < 80);
      end else if (pick == 7) begin
        send_event(1'($urandom_range(0, 1)), TID_W'($urandom()),
                   ADDR_W'({$urandom(), $urandom()}), 1'b1);
      end else begin
        a = addr_pool[$urandom_range(0, MAX_LOCKS + 7)];
        send_event(1'($urandom_range(0, 1)), t, a, 1'b1);
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 1'b0;
    in_valid     = 1'b0;
    in_req_type  = REQ_ACQUIRE;
    in_thread_id = '0;
    in_lock_addr = '0;
    stall_enable = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, nesting, order violation, release cases
    send_event(REQ_RELEASE, 16'h0000, 48'h0, 1'b0);
    send_event(REQ_ACQUIRE, 16'h0000, 48'h0, 1'b0);
    send_event(REQ_ACQUIRE, 16'h0000, 48'hFFFF_FFFF_FFFF, 1'b0);
    send_event(REQ_ACQUIRE, 16'h0000, 48'hFFFF_FFFF_FFFF, 1'b0);
    send_event(REQ_ACQUIRE, 16'h0000, 48'h0, 1'b0);
    send_event(REQ_ACQUIRE, 16'hFFFF, 48'h0, 1'b0);
    send_event(REQ_RELEASE, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
    send_event(REQ_RELEASE, 16'h1234, 48'h0, 1'b0);
    send_event(REQ_RELEASE, 16'h0000, 48'hFFFF_FFFF_FFFF, 1'b0);
    send_event(REQ_RELEASE, 16'h0000, 48'h0, 1'b0);
    send_event(REQ_RELEASE, 16'h0000, 48'hFFFF_FFFF_FFFF, 1'b0);
    send_event(REQ_RELEASE, 16'hFFFF, 48'h0, 1'b0);
    // Held list overflow on one thread
    for (int i = 0; i < 9; i++)
      send_event(REQ_ACQUIRE, 16'h5555, ADDR_W'(48'hAAAA_0000_0000 + i), 1'b0);
    write_nesting(1'b0);
    send_event(REQ_ACQUIRE, 16'h5555, 48'hAAAA_0000_0007, 1'b0);
    send_event(REQ_ACQUIRE, 16'h5555, 48'hAAAA_0000_0003, 1'b0);
    // Thread table overflow
    for (int i = 0; i < MAX_THREADS + 1; i++)
      send_event(REQ_ACQUIRE, TID_W'(16'h0100 + i), 48'h0000_5555_5555, 1'b1);
    // Grow the lock table with new addresses on the known threads
    for (int i = 0; i < MAX_LOCKS; i++)
      send_event(REQ_ACQUIRE, TID_W'(16'h0100 + (i % MAX_THREADS)),
                 ADDR_W'(48'h7000_0000_0000 + i), 1'b1);

    // Random phases: each after a fresh reset would need reset again, so grow
    // small pools first within the now-full thread table, then toggle nesting.
    fill_pools(8, 4);
    for (int i = 0; i < 8; i++) addr_pool[i] = ADDR_W'(48'h7000_0000_0000 + i * 3);
    for (int i = 0; i < 4; i++) tid_pool[i] = TID_W'(16'h0100 + i);
    random_traffic(400);
    write_nesting(1'b1);
    for (int i = 0; i < 20; i++) addr_pool[i] = ADDR_W'(48'h7000_0000_0000 + i);
    addr_span = 20;
    tid_span  = 12;
    for (int i = 0; i < 12; i++) tid_pool[i] = TID_W'(16'h0100 + i);
    random_traffic(450);
    write_nesting(1'b0);
    random_traffic(200);
    write_nesting(1'b1);
    random_traffic(200);

    stall_enable = 1'b1;
    drain_results();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("FAIL");
    $finish;
  end

endmodule

[sim.f]
hdl/lcc_pkg.sv
hdl/lcc_ram.sv
hdl/lcc_lock_cell.sv
hdl/lcc_thr_cell.sv
hdl/lcc_stk_cell.sv
hdl/lock_order_checker_core.sv
tb/lock_order_checker_core_chk.sv
tb/lock_order_checker_core_tb.sv
